@@ hw/rtl/bfha_pkg.sv @@
// Shared constants and types of the best-fit heap allocator.
package bfha_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int MAX_PAGES    = 256;
   localparam int PAGE_SHIFT   = 12;
   localparam int HDR_BYTES    = 16;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int PAGES_W      = 9;
   localparam int SIZE_W       = 21;
   localparam int OFF_W        = 22;
   localparam int ADDR_W       = 48;
   localparam int REQ_W        = 20;
   localparam int GROW_W       = 10;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic              used;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } tbl_wr_type;

endpackage

@@ hw/rtl/bfha_table_mem.sv @@
// Block table memory: one write port, one read port with registered data.
module bfha_table_mem
   import bfha_pkg::*;
(
   input  logic             clock,
   input  tbl_wr_type       wr,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MAX_BLOCKS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/best_fit_heap_allocator_unit.sv @@
// Best-fit heap allocator: block table walk, split, free, and heap growth and trim control.
//
// The allocator works on one request at a time. Every operation walks the
// block table once through the table memory, one entry per cycle. An allocate
// that splits a block in the middle of the table additionally moves every
// later entry up by one place, one entry per cycle. Results leave through an
// output register, so the next request is taken while an earlier result still
// waits. heap_base must only be written while no request is in flight.
module best_fit_heap_allocator_unit
   import bfha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [47:0] csr_tdata,   // heap_base
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // request_size, block_address, zero fill
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // payload_address, success, heap_pages_now, fill
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN   = 7'b0000010,
      S_DECIDE = 7'b0000100,
      S_SHIFT  = 7'b0001000,
      S_WR1    = 7'b0010000,
      S_WR2    = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PAGES_W-1:0] pages_ff, pages_in;
   logic               op_ff, op_in;
   logic [REQ_W-1:0]   n_ff, n_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               vld_ff, vld_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic               best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [SIZE_W-1:0]  best_size_ff, best_size_in;
   logic [OFF_W-1:0]   best_off_ff, best_off_in;
   logic               last_used_ff, last_used_in;
   logic [SIZE_W-1:0]  last_size_ff, last_size_in;
   logic               found_vld_ff, found_vld_in;
   logic [IDX_W-1:0]   found_idx_ff, found_idx_in;
   logic [SIZE_W-1:0]  found_size_ff, found_size_in;
   logic               lu_vld_ff, lu_vld_in;
   logic [IDX_W-1:0]   lu_idx_ff, lu_idx_in;
   logic [OFF_W-1:0]   t_ff, t_in;
   logic [CNT_W-1:0]   sh_ff, sh_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   tbl_wr_type         w1_ff, w1_in, w2_ff, w2_in;
   logic               res_ok_ff, res_ok_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;

   tbl_wr_type       wr;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;

   bfha_table_mem u_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Per-entry scan terms.
   logic             fit, match, used_eff, last_entry;
   // Decision terms.
   logic [OFF_W-1:0] end_b, g_start, g_need, g_newend, t_hdr, f_newend;
   logic             split, last_free, g_fail, trim_ok, sh_active;
   logic [CNT_W-1:0] g_idx;
   logic [CNT_W:0]   g_newcnt;
   logic [GROW_W-1:0] g_grow;
   logic [PAGES_W+1:0] g_pages;
   logic [PAGES_W-1:0] f_k, f_pages;

   always_comb begin
      fit = !rd_data.used && (rd_data.size >= SIZE_W'(n_ff))
            && (!best_vld_ff || rd_data.size < best_size_ff);
      match = !found_vld_ff
              && ((base_ff + ADDR_W'(off_ff) + ADDR_W'(HDR_BYTES)) == addr_ff);
      used_eff = rd_data.used && !match;
      last_entry = ({1'b0, idx_ff} == count_ff - CNT_W'(1));

      end_b = OFF_W'(pages_ff) << PAGE_SHIFT;
      split = (OFF_W'(best_size_ff) > OFF_W'(n_ff) + OFF_W'(HDR_BYTES))
              && (count_ff != CNT_W'(MAX_BLOCKS));
      last_free = (count_ff != '0) && !last_used_ff;
      g_idx = last_free ? count_ff - CNT_W'(1) : count_ff;
      g_start = last_free ? end_b - OFF_W'(HDR_BYTES) - OFF_W'(last_size_ff) : end_b;
      g_newcnt = {1'b0, g_idx} + (CNT_W+1)'(2);
      g_need = g_start + OFF_W'(2 * HDR_BYTES) + OFF_W'(n_ff);
      g_grow = (g_need > end_b)
               ? GROW_W'((g_need - end_b + OFF_W'((1 << PAGE_SHIFT) - 1)) >> PAGE_SHIFT)
               : '0;
      g_pages = (PAGES_W+2)'(pages_ff) + (PAGES_W+2)'(g_grow);
      g_fail = (g_newcnt > (CNT_W+1)'(MAX_BLOCKS))
               || (g_pages > (PAGES_W+2)'(MAX_PAGES));
      g_newend = OFF_W'(g_pages) << PAGE_SHIFT;

      t_hdr = t_ff + OFF_W'(HDR_BYTES);
      trim_ok = (t_hdr <= end_b) && (lu_idx_ff != IDX_W'(MAX_BLOCKS - 1));
      f_k = PAGES_W'((end_b - t_hdr) >> PAGE_SHIFT);
      f_pages = pages_ff - f_k;
      f_newend = OFF_W'(f_pages) << PAGE_SHIFT;

      sh_active = sh_ff > {1'b0, best_idx_ff};
   end

   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      count_in = count_ff;
      pages_in = pages_ff;
      op_in = op_ff;
      n_in = n_ff;
      addr_in = addr_ff;
      issue_in = issue_ff;
      vld_in = 1'b0;
      idx_in = idx_ff;
      off_in = off_ff;
      best_vld_in = best_vld_ff;
      best_idx_in = best_idx_ff;
      best_size_in = best_size_ff;
      best_off_in = best_off_ff;
      last_used_in = last_used_ff;
      last_size_in = last_size_ff;
      found_vld_in = found_vld_ff;
      found_idx_in = found_idx_ff;
      found_size_in = found_size_ff;
      lu_vld_in = lu_vld_ff;
      lu_idx_in = lu_idx_ff;
      t_in = t_ff;
      sh_in = sh_ff;
      pend_in = 1'b0;
      pend_idx_in = pend_idx_ff;
      w1_in = w1_ff;
      w2_in = w2_ff;
      res_ok_in = res_ok_ff;
      res_addr_in = res_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      wr = '0;
      rd_addr = issue_ff[IDX_W-1:0];

      if (csr_tvalid) begin
         base_in = csr_tdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tuser;
               n_in = req_tdata[REQ_W-1:0];
               addr_in = req_tdata[REQ_W+ADDR_W-1:REQ_W];
               issue_in = '0;
               off_in = '0;
               best_vld_in = 1'b0;
               found_vld_in = 1'b0;
               lu_vld_in = 1'b0;
               last_used_in = 1'b0;
               state_in = (count_ff == '0) ? S_DECIDE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue_ff < count_ff) begin
               vld_in = 1'b1;
               idx_in = issue_ff[IDX_W-1:0];
               issue_in = issue_ff + CNT_W'(1);
            end
            if (vld_ff) begin
               off_in = off_ff + OFF_W'(rd_data.size) + OFF_W'(HDR_BYTES);
               last_used_in = rd_data.used;
               last_size_in = rd_data.size;
               if (fit) begin
                  best_vld_in = 1'b1;
                  best_idx_in = idx_ff;
                  best_size_in = rd_data.size;
                  best_off_in = off_ff;
               end
               if (match) begin
                  found_vld_in = 1'b1;
                  found_idx_in = idx_ff;
                  found_size_in = rd_data.size;
               end
               if (used_eff) begin
                  lu_vld_in = 1'b1;
                  lu_idx_in = idx_ff;
                  t_in = off_ff + OFF_W'(rd_data.size) + OFF_W'(HDR_BYTES);
               end
               if (last_entry) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            w2_in.en = 1'b0;
            res_ok_in = 1'b1;
            res_addr_in = '0;
            if (op_ff == OP_ALLOC) begin
               if (best_vld_ff) begin
                  res_addr_in = base_ff + ADDR_W'(best_off_ff) + ADDR_W'(HDR_BYTES);
                  state_in = S_WR1;
                  if (split) begin
                     count_in = count_ff + CNT_W'(1);
                     w1_in = '{en: 1'b1, addr: best_idx_ff,
                               data: '{used: 1'b1, size: SIZE_W'(n_ff)}};
                     w2_in = '{en: 1'b1, addr: best_idx_ff + IDX_W'(1),
                               data: '{used: 1'b0, size: best_size_ff - SIZE_W'(n_ff)
                                                         - SIZE_W'(HDR_BYTES)}};
                     if ({1'b0, best_idx_ff} + CNT_W'(1) < count_ff) begin
                        sh_in = count_ff - CNT_W'(1);
                        state_in = S_SHIFT;
                     end
                  end else begin
                     w1_in = '{en: 1'b1, addr: best_idx_ff,
                               data: '{used: 1'b1, size: best_size_ff}};
                  end
               end else if (g_fail) begin
                  res_ok_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  pages_in = PAGES_W'(g_pages);
                  count_in = CNT_W'(g_newcnt);
                  res_addr_in = base_ff + ADDR_W'(g_start) + ADDR_W'(HDR_BYTES);
                  w1_in = '{en: 1'b1, addr: g_idx[IDX_W-1:0],
                            data: '{used: 1'b1, size: SIZE_W'(n_ff)}};
                  w2_in = '{en: 1'b1, addr: g_idx[IDX_W-1:0] + IDX_W'(1),
                            data: '{used: 1'b0, size: SIZE_W'(g_newend - g_need)}};
                  state_in = S_WR1;
               end
            end else begin
               if (!found_vld_ff) begin
                  res_ok_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  w1_in = '{en: 1'b1, addr: found_idx_ff,
                            data: '{used: 1'b0, size: found_size_ff}};
                  state_in = S_WR1;
                  if (!lu_vld_ff) begin
                     count_in = '0;
                     pages_in = '0;
                  end else if (trim_ok) begin
                     pages_in = f_pages;
                     count_in = CNT_W'(lu_idx_ff) + CNT_W'(2);
                     w2_in = '{en: 1'b1, addr: lu_idx_ff + IDX_W'(1),
                               data: '{used: 1'b0, size: SIZE_W'(f_newend - t_hdr)}};
                  end
               end
            end
         end
         S_SHIFT: begin
            // Entries move up one place, top first; each entry is written in the cycle after its read.
            rd_addr = sh_ff[IDX_W-1:0];
            if (sh_active) begin
               pend_in = 1'b1;
               pend_idx_in = sh_ff[IDX_W-1:0];
               sh_in = sh_ff - CNT_W'(1);
            end
            if (pend_ff) begin
               wr = '{en: 1'b1, addr: pend_idx_ff + IDX_W'(1), data: rd_data};
            end
            if (!sh_active && !pend_ff) begin
               state_in = S_WR1;
            end
         end
         S_WR1: begin
            wr = w1_ff;
            state_in = w2_ff.en ? S_WR2 : S_DONE;
         end
         S_WR2: begin
            wr = w2_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {6'b0, pages_ff, res_ok_ff, res_addr_ff};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff <= '0;
         count_ff <= '0;
         pages_ff <= '0;
         vld_ff <= 1'b0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         count_ff <= count_in;
         pages_ff <= pages_in;
         vld_ff <= vld_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      n_ff <= n_in;
      addr_ff <= addr_in;
      issue_ff <= issue_in;
      idx_ff <= idx_in;
      off_ff <= off_in;
      best_vld_ff <= best_vld_in;
      best_idx_ff <= best_idx_in;
      best_size_ff <= best_size_in;
      best_off_ff <= best_off_in;
      last_used_ff <= last_used_in;
      last_size_ff <= last_size_in;
      found_vld_ff <= found_vld_in;
      found_idx_ff <= found_idx_in;
      found_size_ff <= found_size_in;
      lu_vld_ff <= lu_vld_in;
      lu_idx_ff <= lu_idx_in;
      t_ff <= t_in;
      sh_ff <= sh_in;
      pend_idx_ff <= pend_idx_in;
      w1_ff <= w1_in;
      w2_ff <= w2_in;
      res_ok_ff <= res_ok_in;
      res_addr_ff <= res_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_tready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the best-fit heap allocator unit.
module testbench
   import bfha_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_CYCLES = 200;
   localparam int STALL_LIMIT  = 5000;
   localparam int PAGE_BYTES   = 4096;

   typedef struct {
      logic              op;
      logic [REQ_W-1:0]  size;
      logic [ADDR_W-1:0] addr;
   } heap_request_type;

   typedef struct {
      logic [ADDR_W-1:0]  addr;
      logic               ok;
      logic [PAGES_W-1:0] pages;
   } heap_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [47:0] csr_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   best_fit_heap_allocator_unit DUT (.*);

   always #6 clock = ~clock;

   // Predicted allocator state.
   logic              blk_used [MAX_BLOCKS];
   longint            blk_size [MAX_BLOCKS];
   int                blk_count;
   int                pages_held;
   logic [ADDR_W-1:0] base_addr;

   heap_request_type pending_reqs [$];
   heap_reply_type   expected_replies [$];

   int sender_idle_pct, receiver_idle_pct;
   int mismatches, replies_seen, allocs_sent, frees_sent, good_replies;
   int stall_cycles;
   logic req_beat_taken;

   function automatic logic [ADDR_W-1:0] payload_addr(int idx);
      longint off;
      off = 0;
      for (int i = 0; i < idx && i < blk_count; i++) off += HDR_BYTES + blk_size[i];
      return base_addr + ADDR_W'(off) + ADDR_W'(HDR_BYTES);
   endfunction

   function automatic logic alloc_block(longint n, output logic [ADDR_W-1:0] addr);
      int best, idx;
      longint fin, start, need, grow;
      best = -1;
      addr = '0;
      for (int i = 0; i < blk_count; i++)
         if (!blk_used[i] && blk_size[i] >= n && (best < 0 || blk_size[i] < blk_size[best]))
            best = i;
      if (best >= 0) begin
         blk_used[best] = 1'b1;
         if (blk_size[best] > n + HDR_BYTES && blk_count < MAX_BLOCKS) begin
            for (int j = blk_count - 1; j > best; j--) begin
               blk_used[j+1] = blk_used[j];
               blk_size[j+1] = blk_size[j];
            end
            blk_used[best+1] = 1'b0;
            blk_size[best+1] = blk_size[best] - n - HDR_BYTES;
            blk_size[best] = n;
            blk_count++;
         end
         addr = payload_addr(best);
         return 1'b1;
      end
      fin = longint'(pages_held) * PAGE_BYTES;
      if (blk_count > 0 && !blk_used[blk_count-1]) begin
         idx = blk_count - 1;
         start = fin - HDR_BYTES - blk_size[idx];
      end else begin
         idx = blk_count;
         start = fin;
      end
      if (idx + 2 > MAX_BLOCKS) return 1'b0;
      need = start + 2 * HDR_BYTES + n;
      grow = (need > fin) ? (need - fin + PAGE_BYTES - 1) / PAGE_BYTES : 0;
      if (pages_held + grow > MAX_PAGES) return 1'b0;
      pages_held += int'(grow);
      blk_used[idx] = 1'b1;
      blk_size[idx] = n;
      blk_used[idx+1] = 1'b0;
      blk_size[idx+1] = longint'(pages_held) * PAGE_BYTES - need;
      blk_count = idx + 2;
      addr = payload_addr(idx);
      return 1'b1;
   endfunction

   function automatic logic free_block(logic [ADDR_W-1:0] addr);
      int found, last;
      longint off, tail, fin, k;
      found = -1;
      last = -1;
      off = 0;
      tail = 0;
      for (int i = 0; i < blk_count; i++) begin
         if (base_addr + ADDR_W'(off) + ADDR_W'(HDR_BYTES) == addr) begin
            found = i;
            break;
         end
         off += HDR_BYTES + blk_size[i];
      end
      if (found < 0) return 1'b0;
      blk_used[found] = 1'b0;
      off = 0;
      for (int i = 0; i < blk_count; i++) begin
         off += HDR_BYTES + blk_size[i];
         if (blk_used[i]) begin
            last = i;
            tail = off;
         end
      end
      if (last < 0) begin
         blk_count = 0;
         pages_held = 0;
         return 1'b1;
      end
      fin = longint'(pages_held) * PAGE_BYTES;
      if (tail + HDR_BYTES <= fin && last + 1 < MAX_BLOCKS) begin
         k = (fin - tail - HDR_BYTES) / PAGE_BYTES;
         pages_held -= int'(k);
         blk_used[last+1] = 1'b0;
         blk_size[last+1] = longint'(pages_held) * PAGE_BYTES - tail - HDR_BYTES;
         blk_count = last + 2;
      end
      return 1'b1;
   endfunction

   // Requests are predicted as they are queued; the block answers strictly in order.
   task automatic push_request(logic op, logic [REQ_W-1:0] size, logic [ADDR_W-1:0] addr);
      heap_reply_type r;
      r.addr = '0;
      if (op == OP_ALLOC) begin
         r.ok = alloc_block(longint'(size), r.addr);
         if (!r.ok) r.addr = '0;
         allocs_sent++;
      end else begin
         r.ok = free_block(addr);
         frees_sent++;
      end
      r.pages = PAGES_W'(pages_held);
      pending_reqs.push_back('{op, size, addr});
      expected_replies.push_back(r);
   endtask

   task automatic random_request();
      int pick, idx, live [$];
      logic [ADDR_W-1:0] a;
      if ($urandom_range(99) < 58) begin
         pick = $urandom_range(99);
         if (pick < 78) push_request(OP_ALLOC, REQ_W'($urandom_range(2048)), '0);
         else if (pick < 95) push_request(OP_ALLOC, REQ_W'($urandom_range(40000)), '0);
         else push_request(OP_ALLOC, REQ_W'($urandom_range(1048560)), '0);
      end else begin
         for (int i = 0; i < blk_count; i++) if (blk_used[i]) live.push_back(i);
         pick = $urandom_range(99);
         if (pick < 72 && live.size() > 0) begin
            a = payload_addr(live[$urandom_range(live.size() - 1)]);
         end else if (pick < 82 && blk_count > 0) begin
            a = payload_addr($urandom_range(blk_count - 1));
         end else if (pick < 91 && blk_count > 0) begin
            idx = $urandom_range(blk_count - 1);
            a = payload_addr(idx) + ADDR_W'($urandom_range(1, 15));
         end else begin
            a = ADDR_W'({$urandom, $urandom});
         end
         push_request(OP_FREE, '0, a);
      end
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && expected_replies.size() == 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(logic [ADDR_W-1:0] value);
      @(negedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata <= value;
      do @(posedge clock); while (!csr_tready);
      base_addr = value;
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   // Request driver.
   always @(posedge clock) req_beat_taken <= req_tvalid && req_tready;

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_beat_taken)) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            heap_request_type q;
            q = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= q.op;
            req_tdata <= {4'b0, q.addr, q.size};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !reset && ($urandom_range(99) >= receiver_idle_pct);
   end

   // Reply monitor and progress watchdog.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         heap_reply_type e;
         replies_seen++;
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("reply beat with nothing expected: %h", rsp_tdata);
         end else begin
            e = expected_replies.pop_front();
            if (e.ok) good_replies++;
            if (rsp_tdata[47:0] !== e.addr || rsp_tdata[48] !== e.ok
                || rsp_tdata[57:49] !== e.pages) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("reply %0d: expected addr %h ok %b pages %0d, got addr %h ok %b pages %0d",
                           replies_seen, e.addr, e.ok, e.pages,
                           rsp_tdata[47:0], rsp_tdata[48], rsp_tdata[57:49]);
            end
         end
      end
      if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)
          || (csr_tvalid && csr_tready) || reset)
         stall_cycles <= 0;
      else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("best_fit_heap_allocator_unit test failed");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      logic [ADDR_W-1:0] a;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         blk_used[i] = 1'b0;
         blk_size[i] = 0;
      end
      blk_count = 0;
      pages_held = 0;
      base_addr = '0;
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      mismatches = 0;
      replies_seen = 0;
      allocs_sent = 0;
      frees_sent = 0;
      good_replies = 0;
      stall_cycles = 0;
      req_beat_taken = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: zero and maximal requests, splits, growth and bad frees.
      write_base(48'h1234_5678_9AB0);
      push_request(OP_ALLOC, 20'd0, '0);
      push_request(OP_ALLOC, 20'd100, '0);
      push_request(OP_ALLOC, 20'd1048560, '0);
      push_request(OP_ALLOC, 20'hFFFFF, '0);
      push_request(OP_ALLOC, 20'd5000, '0);
      push_request(OP_FREE, '0, payload_addr(1));
      push_request(OP_ALLOC, 20'd50, '0);
      push_request(OP_FREE, '0, '0);
      push_request(OP_FREE, '0, 48'hFFFF_FFFF_FFFF);
      push_request(OP_FREE, '0, payload_addr(0) + 48'd8);
      push_request(OP_FREE, '0, payload_addr(0));
      push_request(OP_FREE, '0, payload_addr(0));
      push_request(OP_ALLOC, 20'd4080, '0);
      push_request(OP_ALLOC, 20'd4111, '0);
      a = payload_addr(blk_count - 2);
      push_request(OP_FREE, '0, a);
      push_request(OP_ALLOC, 20'd16, '0);
      drain();
      // Moving the base keeps the blocks; the next addresses wrap around the top.
      write_base(48'hFFFF_FFFF_FFF0);
      push_request(OP_ALLOC, 20'd32, '0);
      push_request(OP_FREE, '0, payload_addr(0));
      for (int i = 0; i < blk_count; i++)
         if (blk_used[i]) push_request(OP_FREE, '0, payload_addr(i));
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         sender_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 51 : 0;
         receiver_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 33 : 0;
         write_base(ph == 0 ? 48'h0 : ph == 1 ? 48'hFFFF_FFFF_FFFF
                                             : ADDR_W'({$urandom, $urandom}));
         for (int i = 0; i < 630; i++) begin
            random_request();
            // Keep the queue short so each request sees the state it was built on.
            if (pending_reqs.size() > 8) wait (pending_reqs.size() <= 4);
         end
         drain();
      end

      $display("Ran %0d allocates and %0d frees over five base settings; %0d replies, %0d good.",
               allocs_sent, frees_sent, replies_seen, good_replies);
      if (mismatches == 0) begin
         $display("best_fit_heap_allocator_unit test passed");
      end else begin
         $display("%0d mismatching reply beats", mismatches);
         $display("best_fit_heap_allocator_unit test failed");
      end
      $finish;
   end

endmodule
